// ===== src/mhpq_pkg.sv =====
// ----------------------------------------------------------------------------
// mhpq_pkg
// Shared widths, codes and types of the binary max-heap priority queue.
// ----------------------------------------------------------------------------
package mhpq_pkg;

  localparam int CAPACITY   = 1024;
  localparam int DATA_WIDTH = 32;

  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int ACTION_W = 2;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 11;

  typedef logic signed [DATA_WIDTH-1:0] data_t;
  typedef logic [ADDR_W-1:0]            addr_t;
  typedef logic [CNT_W-1:0]             cnt_t;

  typedef enum logic [ACTION_W-1:0] {
    ACT_PUSH  = 2'd0,
    ACT_POP   = 2'd1,
    ACT_CLEAR = 2'd2
  } action_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_UP_RD,
    ST_UP_CMP,
    ST_DN_ROOT,
    ST_DN_LAST,
    ST_DN_RD_L,
    ST_DN_RD_R,
    ST_DN_CMP,
    ST_DONE
  } state_t;

  // One write and one read request to the heap store per cycle.
  typedef struct packed {
    logic  we;
    addr_t waddr;
    data_t wdata;
    logic  re;
    addr_t raddr;
  } mem_req_t;

endpackage

// ===== src/mhpq_if.sv =====
// ----------------------------------------------------------------------------
// mhpq_in_if / mhpq_out_if
// Valid/ready channels for heap requests and heap results.
// ----------------------------------------------------------------------------
interface mhpq_in_if;
  logic                               valid;
  logic                               ready;
  logic [mhpq_pkg::ACTION_W-1:0]      action;
  logic signed [mhpq_pkg::VALUE_W-1:0] value;

  modport source (output valid, action, value, input ready);
  modport sink   (input valid, action, value, output ready);
endinterface

interface mhpq_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [mhpq_pkg::VALUE_W-1:0] popped_value;
  logic [mhpq_pkg::STATUS_W-1:0]       status;
  logic [mhpq_pkg::COUNT_W-1:0]        element_count;
  logic                                is_empty;

  modport source (output valid, popped_value, status, element_count, is_empty,
                  input ready);
  modport sink   (input valid, popped_value, status, element_count, is_empty,
                  output ready);
endinterface

// ===== src/mhpq_store.sv =====
// ----------------------------------------------------------------------------
// mhpq_store
// Heap element memory: one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module mhpq_store (
  input  logic               clk,
  input  mhpq_pkg::mem_req_t req,
  output mhpq_pkg::data_t    rdata
);

  mhpq_pkg::data_t mem [mhpq_pkg::CAPACITY];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (req.re) begin
      rdata <= mem[req.raddr];
    end
  end

endmodule

// ===== src/max_heap_priority_queue.sv =====
// ----------------------------------------------------------------------------
// max_heap_priority_queue
// Bounded binary max-heap: push, pop of the maximum, and clear.
// ----------------------------------------------------------------------------
//  Channel  Dir  Payload                                          Note
//  in_ch    in   action, value                                    one item
//  out_ch   out  popped_value, status, element_count, is_empty    one per item
//
// One item at a time: a new item is taken only after the last one has placed
// its result in the output register. Clear, refused items and unused action
// codes go straight to the result. A push climbs level by level, reading the
// parent and writing the hole at each level. A pop that empties the heap only
// reads the root; any other pop also reads the last element and sifts it down,
// reading the left and right child in turn through the single read port of the heap store.
// Reset clears the count and the handshakes; the store needs no clearing. A
// stalled result stays in the output register and the next item is taken
// meanwhile; only its own result waits for the slot.
// ----------------------------------------------------------------------------
module max_heap_priority_queue (
  input  logic         clk,
  input  logic         rst_n,
  mhpq_in_if.sink      in_ch,
  mhpq_out_if.source   out_ch
);

  localparam int IDX_W = mhpq_pkg::CNT_W + 1;

  mhpq_pkg::state_t   state_r, state_nxt;
  mhpq_pkg::cnt_t     cnt_r, cnt_nxt;
  mhpq_pkg::addr_t    pos_r, pos_nxt;
  mhpq_pkg::data_t    val_r, val_nxt;
  mhpq_pkg::data_t    left_r, left_nxt;
  logic               has_r_r, has_r_nxt;
  mhpq_pkg::data_t    pop_r, pop_nxt;
  mhpq_pkg::status_t  stat_r, stat_nxt;

  logic                               ovalid_r, ovalid_nxt;
  logic signed [mhpq_pkg::VALUE_W-1:0] opop_r, opop_nxt;
  logic [mhpq_pkg::STATUS_W-1:0]      ostat_r, ostat_nxt;
  logic [mhpq_pkg::COUNT_W-1:0]       ocnt_r, ocnt_nxt;
  logic                               oempty_r, oempty_nxt;

  mhpq_pkg::mem_req_t req;
  mhpq_pkg::data_t    rdata;

  logic               in_xfer;
  mhpq_pkg::action_t  in_act;
  logic [IDX_W-1:0]   l_idx, r_idx, cnt_x;
  mhpq_pkg::addr_t    parent;
  mhpq_pkg::data_t    best_val;
  mhpq_pkg::addr_t    best_pos;
  logic               best_child;

  mhpq_store u_store (
    .clk   (clk),
    .req   (req),
    .rdata (rdata)
  );

  assign in_ch.ready = (state_r == mhpq_pkg::ST_IDLE);
  assign in_xfer     = in_ch.valid && in_ch.ready;
  assign in_act      = mhpq_pkg::action_t'(in_ch.action);

  assign l_idx  = IDX_W'({pos_r, 1'b1});
  assign r_idx  = l_idx + IDX_W'(1);
  assign cnt_x  = IDX_W'(cnt_r);
  assign parent = (pos_r - mhpq_pkg::addr_t'(1)) >> 1;

  // Largest of node, left and right child; a tie keeps the earlier candidate.
  always_comb begin
    best_val   = val_r;
    best_pos   = pos_r;
    best_child = 1'b0;
    if (left_r > val_r) begin
      best_val   = left_r;
      best_pos   = l_idx[mhpq_pkg::ADDR_W-1:0];
      best_child = 1'b1;
    end
    if (has_r_r && (rdata > best_val)) begin
      best_val   = rdata;
      best_pos   = r_idx[mhpq_pkg::ADDR_W-1:0];
      best_child = 1'b1;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    pos_nxt    = pos_r;
    val_nxt    = val_r;
    left_nxt   = left_r;
    has_r_nxt  = has_r_r;
    pop_nxt    = pop_r;
    stat_nxt   = stat_r;
    ovalid_nxt = ovalid_r;
    opop_nxt   = opop_r;
    ostat_nxt  = ostat_r;
    ocnt_nxt   = ocnt_r;
    oempty_nxt = oempty_r;
    req        = '0;

    if (out_ch.ready) begin
      ovalid_nxt = 1'b0;
    end

    // Reads and writes of one sift step fall in separate cycles, so a read
    // always sees the write of the step before it.
    case (state_r)
      mhpq_pkg::ST_IDLE: begin
        if (in_xfer) begin
          pop_nxt   = '0;
          stat_nxt  = mhpq_pkg::STAT_OK;
          state_nxt = mhpq_pkg::ST_DONE;
          case (in_act)
            mhpq_pkg::ACT_PUSH: begin
              if (cnt_r >= mhpq_pkg::cnt_t'(mhpq_pkg::CAPACITY)) begin
                stat_nxt = mhpq_pkg::STAT_FULL;
              end else begin
                val_nxt   = mhpq_pkg::data_t'(in_ch.value);
                pos_nxt   = cnt_r[mhpq_pkg::ADDR_W-1:0];
                cnt_nxt   = cnt_r + mhpq_pkg::cnt_t'(1);
                state_nxt = mhpq_pkg::ST_UP_RD;
              end
            end
            mhpq_pkg::ACT_POP: begin
              if (cnt_r == '0) begin
                stat_nxt = mhpq_pkg::STAT_EMPTY;
              end else begin
                cnt_nxt   = cnt_r - mhpq_pkg::cnt_t'(1);
                req.re    = 1'b1;
                req.raddr = '0;
                state_nxt = mhpq_pkg::ST_DN_ROOT;
              end
            end
            mhpq_pkg::ACT_CLEAR: begin
              cnt_nxt = '0;
            end
            default: begin
            end
          endcase
        end
      end

      mhpq_pkg::ST_UP_RD: begin
        if (pos_r == '0) begin
          req.we    = 1'b1;
          req.waddr = pos_r;
          req.wdata = val_r;
          state_nxt = mhpq_pkg::ST_DONE;
        end else begin
          req.re    = 1'b1;
          req.raddr = parent;
          state_nxt = mhpq_pkg::ST_UP_CMP;
        end
      end

      mhpq_pkg::ST_UP_CMP: begin
        req.we    = 1'b1;
        req.waddr = pos_r;
        if (val_r > rdata) begin
          // The parent moves down into the hole and the climb goes on.
          req.wdata = rdata;
          pos_nxt   = parent;
          state_nxt = mhpq_pkg::ST_UP_RD;
        end else begin
          req.wdata = val_r;
          state_nxt = mhpq_pkg::ST_DONE;
        end
      end

      mhpq_pkg::ST_DN_ROOT: begin
        pop_nxt = rdata;
        if (cnt_r == '0) begin
          state_nxt = mhpq_pkg::ST_DONE;
        end else begin
          req.re    = 1'b1;
          req.raddr = cnt_r[mhpq_pkg::ADDR_W-1:0];
          state_nxt = mhpq_pkg::ST_DN_LAST;
        end
      end

      mhpq_pkg::ST_DN_LAST: begin
        val_nxt   = rdata;
        pos_nxt   = '0;
        state_nxt = mhpq_pkg::ST_DN_RD_L;
      end

      mhpq_pkg::ST_DN_RD_L: begin
        if (l_idx < cnt_x) begin
          req.re    = 1'b1;
          req.raddr = l_idx[mhpq_pkg::ADDR_W-1:0];
          state_nxt = mhpq_pkg::ST_DN_RD_R;
        end else begin
          req.we    = 1'b1;
          req.waddr = pos_r;
          req.wdata = val_r;
          state_nxt = mhpq_pkg::ST_DONE;
        end
      end

      mhpq_pkg::ST_DN_RD_R: begin
        left_nxt  = rdata;
        has_r_nxt = (r_idx < cnt_x);
        if (r_idx < cnt_x) begin
          req.re    = 1'b1;
          req.raddr = r_idx[mhpq_pkg::ADDR_W-1:0];
        end
        state_nxt = mhpq_pkg::ST_DN_CMP;
      end

      mhpq_pkg::ST_DN_CMP: begin
        req.we    = 1'b1;
        req.waddr = pos_r;
        req.wdata = best_val;
        if (best_child) begin
          pos_nxt   = best_pos;
          state_nxt = mhpq_pkg::ST_DN_RD_L;
        end else begin
          state_nxt = mhpq_pkg::ST_DONE;
        end
      end

      mhpq_pkg::ST_DONE: begin
        if (!ovalid_r || out_ch.ready) begin
          ovalid_nxt = 1'b1;
          opop_nxt   = mhpq_pkg::VALUE_W'(pop_r);
          ostat_nxt  = stat_r;
          ocnt_nxt   = mhpq_pkg::COUNT_W'(cnt_r);
          oempty_nxt = (cnt_r == '0);
          state_nxt  = mhpq_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = mhpq_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= mhpq_pkg::ST_IDLE;
      cnt_r    <= '0;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r    <= pos_nxt;
    val_r    <= val_nxt;
    left_r   <= left_nxt;
    has_r_r  <= has_r_nxt;
    pop_r    <= pop_nxt;
    stat_r   <= stat_nxt;
    opop_r   <= opop_nxt;
    ostat_r  <= ostat_nxt;
    ocnt_r   <= ocnt_nxt;
    oempty_r <= oempty_nxt;
  end

  assign out_ch.valid         = ovalid_r;
  assign out_ch.popped_value  = opop_r;
  assign out_ch.status        = ostat_r;
  assign out_ch.element_count = ocnt_r;
  assign out_ch.is_empty      = oempty_r;

endmodule
